// ===== design/dee_pkg.sv =====
// Shared types and constants of the data EEPROM controller.
`timescale 1ns / 1ps
`default_nettype none

package dee_pkg;

  localparam int ADDR_BITS  = 8;
  localparam int CELL_COUNT = 1 << ADDR_BITS;

  localparam logic [7:0]  UNLOCK_FIRST  = 8'h55;
  localparam logic [7:0]  UNLOCK_SECOND = 8'hAA;
  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
  localparam logic [15:0] TICKS_RESET   = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    SEL_ADDR    = 3'd0,
    SEL_DATA    = 3'd1,
    SEL_CONTROL = 3'd2,
    SEL_UNLOCK  = 3'd3,
    SEL_DONE    = 3'd4
  } reg_sel_t;

  typedef enum logic [1:0] {
    UNLOCK_IDLE  = 2'd0,
    UNLOCK_HALF  = 2'd1,
    UNLOCK_ARMED = 2'd2
  } unlock_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== design/data_eeprom_controller.sv =====
// Top level of the data EEPROM controller: register file, unlock logic and cell store.
// The result strobe is registered, in the cycle after an accepted item; a control write
// setting the read bit in data space goes through the fetch state for the RAM read and
// gets its strobe from that state. Throughput: one item per cycle unless busy is high;
// results cannot stall. Reset (synchronous, rst high) clears its register file, sets
// write_ticks to 1000 and marks every cell erased (0xFF) at once by per-cell valid bits.
`timescale 1ns / 1ps
`default_nettype none

module data_eeprom_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  reg_sel,
  input  wire logic [7:0]  wdata,
  output logic             result_valid,
  output logic      [7:0]  rdata,
  output logic             busy_res,
  output logic             done_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_BITS = dee_pkg::ADDR_BITS;

  dee_pkg::state_t  state, state_next;
  dee_pkg::unlock_t unlock_stage, unlock_stage_next;

  logic [15:0] write_ticks;
  logic [7:0]  addr_reg, addr_reg_next;
  logic [7:0]  data_reg, data_reg_next;
  logic [1:0]  space_bits, space_bits_next;
  logic        write_enable, write_enable_next;
  logic        write_active, write_active_next;
  logic [15:0] ticks_left, ticks_left_next;
  logic        done_flag, done_flag_next;
  logic [7:0]  rd_value;
  logic        emit_now;

  logic [dee_pkg::CELL_COUNT-1:0] cell_valid;
  logic                           fetch_valid;
  logic [IDX_BITS-1:0]            cell_idx;
  logic                           ram_we, ram_re;
  logic [7:0]                     ram_rdata;
  logic [7:0]                     fetched;

  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cell_idx  = IDX_BITS'(addr_reg);
  assign fetched   = fetch_valid ? ram_rdata : dee_pkg::ERASED_BYTE;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dee_pkg::ST_IDLE:  if (ram_re) state_next = dee_pkg::ST_FETCH;
      dee_pkg::ST_FETCH: state_next = dee_pkg::ST_IDLE;
      default:           state_next = dee_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy = 1'b0;
    case (state)
      dee_pkg::ST_IDLE:  busy = 1'b0;
      dee_pkg::ST_FETCH: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // Register file update for one accepted item or a finished cell fetch.
  always_comb begin
    addr_reg_next     = addr_reg;
    data_reg_next     = data_reg;
    space_bits_next   = space_bits;
    write_enable_next = write_enable;
    write_active_next = write_active;
    unlock_stage_next = unlock_stage;
    ticks_left_next   = ticks_left;
    done_flag_next    = done_flag;
    rd_value          = 8'h00;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    emit_now          = 1'b0;

    if (state == dee_pkg::ST_FETCH) begin
      data_reg_next = fetched;
    end else if (accept) begin
      emit_now = 1'b1;
      case (dee_pkg::func_t'(func))
        dee_pkg::FUNC_READ: begin
          unlock_stage_next = dee_pkg::UNLOCK_IDLE;
          case (dee_pkg::reg_sel_t'(reg_sel))
            dee_pkg::SEL_ADDR:    rd_value = addr_reg;
            dee_pkg::SEL_DATA:    rd_value = data_reg;
            dee_pkg::SEL_CONTROL: rd_value = {space_bits, 3'b000, write_enable,
                                              write_active, 1'b0};
            dee_pkg::SEL_DONE:    rd_value = {7'b0, done_flag};
            default:              rd_value = 8'h00;
          endcase
        end
        dee_pkg::FUNC_WRITE: begin
          unlock_stage_next = dee_pkg::UNLOCK_IDLE;
          case (dee_pkg::reg_sel_t'(reg_sel))
            dee_pkg::SEL_ADDR: if (!write_active) addr_reg_next = wdata;
            dee_pkg::SEL_DATA: if (!write_active) data_reg_next = wdata;
            dee_pkg::SEL_CONTROL: begin
              space_bits_next   = wdata[7:6];
              write_enable_next = wdata[2];
              if (!write_active && wdata[7:6] == 2'b00) begin
                // The cell read finishes in the fetch cycle, which emits the result.
                if (wdata[0]) begin
                  ram_re   = 1'b1;
                  emit_now = 1'b0;
                end
                if (wdata[1] && wdata[2] && unlock_stage == dee_pkg::UNLOCK_ARMED) begin
                  write_active_next = 1'b1;
                  ticks_left_next   = (write_ticks == 16'd0) ? 16'd1 : write_ticks;
                end
              end
            end
            dee_pkg::SEL_UNLOCK: begin
              if (wdata == dee_pkg::UNLOCK_FIRST) begin
                unlock_stage_next = dee_pkg::UNLOCK_HALF;
              end else if (wdata == dee_pkg::UNLOCK_SECOND &&
                           unlock_stage == dee_pkg::UNLOCK_HALF) begin
                unlock_stage_next = dee_pkg::UNLOCK_ARMED;
              end
            end
            dee_pkg::SEL_DONE: done_flag_next = wdata[0];
            default: ;
          endcase
        end
        dee_pkg::FUNC_TICK: begin
          if (write_active) begin
            if (ticks_left > 16'd1) begin
              ticks_left_next = ticks_left - 16'd1;
            end else begin
              ticks_left_next   = 16'd0;
              ram_we            = 1'b1;
              write_active_next = 1'b0;
              done_flag_next    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dee_pkg::ST_IDLE;
      write_ticks  <= dee_pkg::TICKS_RESET;
      addr_reg     <= 8'h00;
      data_reg     <= 8'h00;
      space_bits   <= 2'b00;
      write_enable <= 1'b0;
      write_active <= 1'b0;
      unlock_stage <= dee_pkg::UNLOCK_IDLE;
      ticks_left   <= 16'd0;
      done_flag    <= 1'b0;
      cell_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      addr_reg     <= addr_reg_next;
      data_reg     <= data_reg_next;
      space_bits   <= space_bits_next;
      write_enable <= write_enable_next;
      write_active <= write_active_next;
      unlock_stage <= unlock_stage_next;
      ticks_left   <= ticks_left_next;
      done_flag    <= done_flag_next;
      result_valid <= emit_now || (state == dee_pkg::ST_FETCH);
      if (cfg_valid && cfg_ready) begin
        write_ticks <= cfg_data;
      end
      if (ram_we) begin
        cell_valid[cell_idx] <= 1'b1;
      end
    end
  end

  // Result payload and the erased-cell marker need no reset.
  always_ff @(posedge clk) begin
    rdata    <= rd_value;
    busy_res <= write_active_next;
    done_res <= done_flag_next;
    if (ram_re) begin
      fetch_valid <= cell_valid[cell_idx];
    end
  end

  dee_ram #(
    .WIDTH (8),
    .DEPTH (dee_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_idx),
    .wdata (data_reg),
    .re    (ram_re),
    .raddr (cell_idx),
    .rdata (ram_rdata)
  );

  a_fetch_emits: assert property (@(posedge clk) disable iff (rst)
    state == dee_pkg::ST_FETCH |=> result_valid)
    else $error("cell fetch did not produce a result");

  a_active_has_ticks: assert property (@(posedge clk) disable iff (rst)
    write_active |-> ticks_left != 16'd0)
    else $error("write in progress with no ticks left");

  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("cell RAM read and write in the same cycle");

  a_write_only_active: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> write_active && (state == dee_pkg::ST_IDLE))
    else $error("cell write outside an active byte write");

  a_start_needs_arm: assert property (@(posedge clk) disable iff (rst)
    $rose(write_active) |-> $past(unlock_stage) == dee_pkg::UNLOCK_ARMED)
    else $error("byte write started without the unlock sequence");

endmodule

`default_nettype wire

// ===== design/dee_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module dee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_data_eeprom_controller.sv =====
// Self-checking testbench for the data EEPROM controller.
`timescale 1ns / 1ps

module tb_data_eeprom_controller;
  import dee_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       busy_res;
    logic       done_res;
  } result_t;

  typedef struct {
    logic [1:0] f;
    logic [2:0] s;
    logic [7:0] v;
    bit         typed;
    result_t    res;
  } step_t;

  localparam int DIRECTED_COUNT = 27;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_READ;
  logic [2:0]  reg_sel = SEL_ADDR;
  logic [7:0]  wdata = 8'h00;
  logic        result_valid;
  logic [7:0]  rdata;
  logic        busy_res;
  logic        done_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  // Shadow copy of the EEPROM and its register file.
  logic [7:0]  ee_cells [CELL_COUNT];
  logic [7:0]  ee_addr;
  logic [7:0]  ee_data;
  logic [1:0]  ee_space;
  logic        ee_enable;
  logic        ee_active;
  unlock_t     ee_unlock;
  logic [15:0] ee_ticks_left;
  logic        ee_done;
  logic [15:0] ee_write_ticks;

  result_t pending_results [$];
  result_t want;
  int      mismatches = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  int      bytes_programmed = 0;
  bit      pace_gaps = 1'b0;
  int      burst_left = 0;

  // Rows with typed expectations are those whose answer is plain from the
  // reset state, the unlock rules or the done flag; the others use the shadow.
  step_t directed_steps [DIRECTED_COUNT] = '{
    '{FUNC_READ,  SEL_ADDR,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_CONTROL, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_UNLOCK,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_DONE,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  3'd7,        8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_NONE,  SEL_ADDR,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_ADDR,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_CONTROL, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_DATA,    8'h00, 1'b1, '{ERASED_BYTE, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_CONTROL, 8'h06, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_UNLOCK,  8'h55, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_UNLOCK,  8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_DATA,    8'h5A, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_CONTROL, 8'h06, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_UNLOCK,  8'h55, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_UNLOCK,  8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_CONTROL, 8'h06, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{FUNC_WRITE, SEL_ADDR,    8'h12, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_CONTROL, 8'h00, 1'b1, '{8'h06, 1'b1, 1'b0}},
    '{FUNC_TICK,  SEL_ADDR,    8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_TICK,  SEL_ADDR,    8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_TICK,  SEL_ADDR,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{FUNC_WRITE, SEL_CONTROL, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_DATA,    8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_DONE,    8'hFE, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_WRITE, SEL_CONTROL, 8'hC3, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{FUNC_READ,  SEL_CONTROL, 8'h00, 1'b1, '{8'hC0, 1'b0, 1'b0}}
  };

  data_eeprom_controller uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .reg_sel      (reg_sel),
    .wdata        (wdata),
    .result_valid (result_valid),
    .rdata        (rdata),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic eeprom_access(input logic [1:0] f, input logic [2:0] s,
                               input logic [7:0] v, output result_t r);
    logic armed;
    r = '0;
    case (f)
      FUNC_READ: begin
        case (s)
          SEL_ADDR:    r.rdata = ee_addr;
          SEL_DATA:    r.rdata = ee_data;
          SEL_CONTROL: r.rdata = {ee_space, 3'b000, ee_enable, ee_active, 1'b0};
          SEL_DONE:    r.rdata = {7'd0, ee_done};
          default:     r.rdata = 8'h00;
        endcase
        ee_unlock = UNLOCK_IDLE;
      end
      FUNC_WRITE: begin
        if (s == SEL_UNLOCK) begin
          if (v == UNLOCK_FIRST)
            ee_unlock = UNLOCK_HALF;
          else if (v == UNLOCK_SECOND && ee_unlock == UNLOCK_HALF)
            ee_unlock = UNLOCK_ARMED;
          else
            ee_unlock = UNLOCK_IDLE;
        end else begin
          // A control write sees the unlock stage before it is cleared.
          armed = (ee_unlock == UNLOCK_ARMED);
          case (s)
            SEL_ADDR: if (!ee_active) ee_addr = v;
            SEL_DATA: if (!ee_active) ee_data = v;
            SEL_CONTROL: begin
              ee_space = v[7:6];
              ee_enable = v[2];
              if (!ee_active && ee_space == 2'b00) begin
                if (v[0]) ee_data = ee_cells[ee_addr[ADDR_BITS-1:0]];
                if (v[1] && ee_enable && armed) begin
                  ee_active = 1'b1;
                  ee_ticks_left = (ee_write_ticks == 16'd0) ? 16'd1 : ee_write_ticks;
                end
              end
            end
            SEL_DONE: ee_done = v[0];
            default: ;
          endcase
          ee_unlock = UNLOCK_IDLE;
        end
      end
      FUNC_TICK: begin
        if (ee_active) begin
          if (ee_ticks_left > 16'd1) begin
            ee_ticks_left--;
          end else begin
            ee_ticks_left = 16'd0;
            ee_cells[ee_addr[ADDR_BITS-1:0]] = ee_data;
            ee_active = 1'b0;
            ee_done = 1'b1;
            bytes_programmed++;
          end
        end
      end
      default: ;
    endcase
    r.busy_res = ee_active;
    r.done_res = ee_done;
  endtask

  task automatic issue(input logic [1:0] f, input logic [2:0] s, input logic [7:0] v,
                       input bit typed = 1'b0, input result_t typed_res = '0);
    result_t r;
    start <= 1'b1;
    func <= f;
    reg_sel <= s;
    wdata <= v;
    do @(posedge clk); while (busy);
    eeprom_access(f, s, v, r);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic finish_write();
    while (ee_active) issue(FUNC_TICK, 3'($urandom), 8'($urandom));
  endtask

  // The register may only change while the block is quiet, so any byte write
  // in flight is ticked to completion and all results are collected first.
  task automatic set_write_ticks(input logic [15:0] t);
    finish_write();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ee_write_ticks = t;
  endtask

  task automatic program_and_verify(input logic [7:0] a, input logic [7:0] d);
    issue(FUNC_WRITE, SEL_ADDR, a);
    issue(FUNC_WRITE, SEL_DATA, d);
    issue(FUNC_WRITE, SEL_UNLOCK, UNLOCK_FIRST);
    issue(FUNC_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
    issue(FUNC_WRITE, SEL_CONTROL, 8'h06);
    finish_write();
    issue(FUNC_WRITE, SEL_DATA, ~d);
    issue(FUNC_WRITE, SEL_CONTROL, 8'h01);
    issue(FUNC_READ, SEL_DATA, 8'h00);
    issue(FUNC_WRITE, SEL_DONE, 8'h00);
  endtask

  task automatic random_sequence();
    int kind;
    logic [7:0] first_key;
    logic [7:0] second_key;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // Unlocked byte write with random content, poked at while it runs.
      issue(FUNC_WRITE, SEL_ADDR, 8'($urandom));
      issue(FUNC_WRITE, SEL_DATA, 8'($urandom));
      issue(FUNC_WRITE, SEL_UNLOCK, UNLOCK_FIRST);
      issue(FUNC_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
      issue(FUNC_WRITE, SEL_CONTROL, 8'h06 | (8'($urandom) & 8'h39));
      while (ee_active) begin
        if ($urandom_range(0, 3) == 0)
          issue(2'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
        issue(FUNC_TICK, 3'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 1)) issue(FUNC_READ, SEL_DONE, 8'($urandom));
      issue(FUNC_WRITE, SEL_DONE, 8'($urandom));
    end else if (kind < 65) begin
      issue(FUNC_WRITE, SEL_ADDR, 8'($urandom));
      issue(FUNC_WRITE, SEL_CONTROL, 8'h01 | (8'($urandom) & 8'h3E));
      issue(FUNC_READ, SEL_DATA, 8'($urandom));
    end else if (kind < 80) begin
      // Unlock attempts that may or may not arm; ticks keep the stage.
      first_key = $urandom_range(0, 1) ? UNLOCK_FIRST : 8'($urandom);
      second_key = $urandom_range(0, 1) ? UNLOCK_SECOND : 8'($urandom);
      issue(FUNC_WRITE, SEL_UNLOCK, first_key);
      if ($urandom_range(0, 2) == 0) issue(FUNC_TICK, 3'($urandom), 8'($urandom));
      issue(FUNC_WRITE, SEL_UNLOCK, second_key);
      case ($urandom_range(0, 3))
        0: issue(FUNC_TICK, 3'($urandom), 8'($urandom));
        1: issue(FUNC_READ, 3'($urandom), 8'($urandom));
        2: issue(FUNC_WRITE, SEL_UNLOCK, 8'($urandom));
        default: ;
      endcase
      issue(FUNC_WRITE, SEL_CONTROL, 8'($urandom) | 8'h06);
    end else begin
      issue(2'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_phase(input logic [15:0] t, input int count);
    int first;
    set_write_ticks(t);
    pace_gaps = 1'b1;
    first = items_sent;
    while (items_sent - first < count) random_sequence();
    pace_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: rdata %0h busy_res %0b done_res %0b",
               rdata, busy_res, done_res);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rdata !== want.rdata) begin
          $error("rdata: expected %0h, got %0h", want.rdata, rdata);
          mismatches++;
        end
        if (busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
          mismatches++;
        end
        if (done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, done_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    foreach (ee_cells[i]) ee_cells[i] = ERASED_BYTE;
    ee_addr = 8'h00;
    ee_data = 8'h00;
    ee_space = 2'b00;
    ee_enable = 1'b0;
    ee_active = 1'b0;
    ee_unlock = UNLOCK_IDLE;
    ee_ticks_left = 16'd0;
    ee_done = 1'b0;
    ee_write_ticks = TICKS_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_write_ticks(16'd3);
    foreach (directed_steps[i])
      issue(directed_steps[i].f, directed_steps[i].s, directed_steps[i].v,
            directed_steps[i].typed, directed_steps[i].res);

    set_write_ticks(16'd12);
    program_and_verify(8'h00, 8'hA5);

    random_phase(16'd1, 90);
    random_phase(16'd0, 90);
    random_phase(16'd2, 90);
    random_phase(16'd5, 90);
    random_phase(16'd7, 90);

    set_write_ticks(16'd20);
    program_and_verify(8'h80, 8'h3C);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d accesses and ticks, checked %0d results, %0d bytes programmed.",
             items_sent, results_seen, bytes_programmed);
    $display("write_ticks settings run: 3, 12, 1, 0, 2, 5, 7 and 20.");
    if (mismatches == 0)
      $display("tb_data_eeprom_controller: done, clean");
    else
      $display("tb_data_eeprom_controller: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("tb_data_eeprom_controller: done, errors");
    $finish;
  end

endmodule
